@@ rtl/bfpa_pkg.sv @@
// Package for the best-fit partition allocator.
// Holds the beat structs, request and status codes, sequencer states and CSR map.
// No dependencies.
package bfpa_pkg;

   localparam int FIELD_SIZE_BITS = 16;
   localparam int FIELD_IDX_BITS  = 4;
   localparam int ACTIVE_BITS     = 5;
   localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = 5'd16;

   // CSR map: one 32-bit register, word index taken from paddr[2]
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic CSR_IDX_ACTIVE = 1'b0;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_ALLOC = 2'd1,
      REQ_READ  = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_NOFIT = 2'd1,
      ST_RANGE = 2'd2
   } status_code_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_READ,
      S_READ_WAIT,
      S_SCAN,
      S_COMMIT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]                  req_type;
      logic [FIELD_IDX_BITS-1:0]   block_index;
      logic [FIELD_SIZE_BITS-1:0]  new_size;
      logic [FIELD_SIZE_BITS-1:0]  request_size;
      logic [7:0]                  process_id;
   } req_beat_type;

   typedef struct packed {
      logic [1:0]                  status;
      logic [FIELD_IDX_BITS-1:0]   entry_index;
      logic                        entry_allocated;
      logic [7:0]                  entry_owner;
      logic [FIELD_SIZE_BITS-1:0]  entry_size;
      logic [FIELD_SIZE_BITS-1:0]  entry_leftover;
   } rsp_beat_type;

   // write-port control between sequencer and partition store
   typedef struct packed {
      logic en;
      logic size_en;
      logic used;
   } wr_ctl_type;

endpackage

@@ rtl/bfpa_store.sv @@
// Partition store: size, owner and leftover memories plus the used-flag vector.
// One write port, one registered read port. Uses bfpa_pkg.
module bfpa_store #(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_BITS  = 16,
   parameter int IDX_BITS   = $clog2(NUM_BLOCKS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bfpa_pkg::wr_ctl_type   wr_ctl,
   input  logic [IDX_BITS-1:0]    wr_addr,
   input  logic [SIZE_BITS-1:0]   wr_size,
   input  logic [7:0]             wr_owner,
   input  logic [SIZE_BITS-1:0]   wr_leftover,
   input  logic                   rd_en,
   input  logic [IDX_BITS-1:0]    rd_addr,
   output logic [SIZE_BITS-1:0]   rd_size,
   output logic [7:0]             rd_owner,
   output logic [SIZE_BITS-1:0]   rd_leftover,
   output logic                   rd_used
);

   logic [SIZE_BITS-1:0] size_mem [NUM_BLOCKS];
   logic [7:0]           owner_mem [NUM_BLOCKS];
   logic [SIZE_BITS-1:0] left_mem [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0] used_ff;

   logic [SIZE_BITS-1:0] rd_size_ff;
   logic [7:0]           rd_owner_ff;
   logic [SIZE_BITS-1:0] rd_left_ff;
   logic                 rd_used_ff;

   always_ff @(posedge clock) begin
      if (wr_ctl.en) begin
         if (wr_ctl.size_en) begin
            size_mem[wr_addr] <= wr_size;
         end
         owner_mem[wr_addr] <= wr_owner;
         left_mem[wr_addr]  <= wr_leftover;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_size_ff  <= size_mem[rd_addr];
         rd_owner_ff <= owner_mem[rd_addr];
         rd_left_ff  <= left_mem[rd_addr];
         rd_used_ff  <= used_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (wr_ctl.en) begin
         used_ff[wr_addr] <= wr_ctl.used;
      end
   end

   assign rd_size     = rd_size_ff;
   assign rd_owner    = rd_owner_ff;
   assign rd_leftover = rd_left_ff;
   assign rd_used     = rd_used_ff;

endmodule

@@ rtl/bfpa_engine.sv @@
// Request sequencer with the shared best-fit comparator and the result register.
// Drives the partition store; uses bfpa_pkg.
module bfpa_engine #(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_BITS  = 16,
   parameter int IDX_BITS   = $clog2(NUM_BLOCKS)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [bfpa_pkg::ACTIVE_BITS-1:0]  active_blocks,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bfpa_pkg::req_beat_type            req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bfpa_pkg::rsp_beat_type            rsp_data,
   output bfpa_pkg::wr_ctl_type              wr_ctl,
   output logic [IDX_BITS-1:0]               wr_addr,
   output logic [SIZE_BITS-1:0]              wr_size,
   output logic [7:0]                        wr_owner,
   output logic [SIZE_BITS-1:0]              wr_leftover,
   output logic                              rd_en,
   output logic [IDX_BITS-1:0]               rd_addr,
   input  logic [SIZE_BITS-1:0]              rd_size,
   input  logic [7:0]                        rd_owner,
   input  logic [SIZE_BITS-1:0]              rd_leftover,
   input  logic                              rd_used
);

   localparam int CNT_RAW  = $clog2(NUM_BLOCKS + 1);
   localparam int CNT_BITS = (CNT_RAW > bfpa_pkg::ACTIVE_BITS) ? CNT_RAW
                                                              : bfpa_pkg::ACTIVE_BITS;
   localparam int FSB = bfpa_pkg::FIELD_SIZE_BITS;
   localparam int FIB = bfpa_pkg::FIELD_IDX_BITS;

   bfpa_pkg::state_type    state_ff, state_in;
   bfpa_pkg::req_beat_type req_ff, req_in;
   bfpa_pkg::rsp_beat_type res_ff, res_in;
   bfpa_pkg::rsp_beat_type rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CNT_BITS-1:0]    scan_ff, scan_in;
   logic                   pend_ff, pend_in;
   logic [IDX_BITS-1:0]    pend_idx_ff, pend_idx_in;
   logic                   found_ff, found_in;
   logic [IDX_BITS-1:0]    best_idx_ff, best_idx_in;
   logic [SIZE_BITS-1:0]   best_size_ff, best_size_in;

   logic [CNT_BITS-1:0]  count;
   logic                 in_range;
   logic [SIZE_BITS-1:0] load_size;
   logic [SIZE_BITS-1:0] want_size;
   logic [SIZE_BITS-1:0] best_left;

   // effective partition count, saturated at the table depth
   assign count = (CNT_BITS'(active_blocks) > CNT_BITS'(NUM_BLOCKS)) ? CNT_BITS'(NUM_BLOCKS)
                                                                    : CNT_BITS'(active_blocks);
   assign in_range  = CNT_BITS'(req_data.block_index) < count;
   assign load_size = SIZE_BITS'(req_ff.new_size);
   assign want_size = SIZE_BITS'(req_ff.request_size);
   assign best_left = best_size_ff - want_size;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfpa_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
      scan_ff      <= scan_in;
      pend_idx_ff  <= pend_idx_in;
      best_idx_ff  <= best_idx_in;
      best_size_ff <= best_size_in;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      scan_in      = scan_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_size_in = best_size_ff;
      req_ready    = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = scan_ff[IDX_BITS-1:0];
      wr_ctl       = '0;
      wr_addr      = best_idx_ff;
      wr_size      = load_size;
      wr_owner     = req_ff.process_id;
      wr_leftover  = best_left;

      case (state_ff)
         bfpa_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in = req_data;
               res_in = '{status: bfpa_pkg::ST_RANGE, entry_index: req_data.block_index,
                          entry_allocated: 1'b0, entry_owner: 8'd0,
                          entry_size: '0, entry_leftover: '0};
               case (req_data.req_type)
                  bfpa_pkg::REQ_LOAD: begin
                     state_in = in_range ? bfpa_pkg::S_LOAD : bfpa_pkg::S_RESP;
                  end
                  bfpa_pkg::REQ_READ: begin
                     state_in = in_range ? bfpa_pkg::S_READ : bfpa_pkg::S_RESP;
                  end
                  bfpa_pkg::REQ_ALLOC: begin
                     scan_in  = '0;
                     found_in = 1'b0;
                     state_in = bfpa_pkg::S_SCAN;
                  end
                  default: begin
                     state_in = bfpa_pkg::S_IDLE;
                  end
               endcase
            end
         end

         bfpa_pkg::S_LOAD: begin
            wr_ctl      = '{en: 1'b1, size_en: 1'b1, used: 1'b0};
            wr_addr     = IDX_BITS'(req_ff.block_index);
            wr_owner    = 8'd0;
            wr_leftover = load_size;
            res_in = '{status: bfpa_pkg::ST_OK, entry_index: req_ff.block_index,
                       entry_allocated: 1'b0, entry_owner: 8'd0,
                       entry_size: FSB'(load_size), entry_leftover: FSB'(load_size)};
            state_in = bfpa_pkg::S_RESP;
         end

         bfpa_pkg::S_READ: begin
            rd_en    = 1'b1;
            rd_addr  = IDX_BITS'(req_ff.block_index);
            state_in = bfpa_pkg::S_READ_WAIT;
         end

         bfpa_pkg::S_READ_WAIT: begin
            res_in = '{status: bfpa_pkg::ST_OK, entry_index: req_ff.block_index,
                       entry_allocated: rd_used,
                       entry_owner: rd_used ? rd_owner : 8'd0,
                       entry_size: FSB'(rd_size), entry_leftover: FSB'(rd_leftover)};
            state_in = bfpa_pkg::S_RESP;
         end

         bfpa_pkg::S_SCAN: begin
            // compare the entry fetched last cycle while the next one is fetched
            if (pend_ff && !rd_used && (rd_size >= want_size) &&
                (!found_ff || (rd_size < best_size_ff))) begin
               found_in     = 1'b1;
               best_idx_in  = pend_idx_ff;
               best_size_in = rd_size;
            end
            if (scan_ff < count) begin
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[IDX_BITS-1:0];
               scan_in     = scan_ff + CNT_BITS'(1);
            end else if (!pend_ff) begin
               if (found_ff) begin
                  state_in = bfpa_pkg::S_COMMIT;
               end else begin
                  res_in = '{status: bfpa_pkg::ST_NOFIT, entry_index: '0,
                             entry_allocated: 1'b0, entry_owner: 8'd0,
                             entry_size: '0, entry_leftover: '0};
                  state_in = bfpa_pkg::S_RESP;
               end
            end
         end

         bfpa_pkg::S_COMMIT: begin
            wr_ctl = '{en: 1'b1, size_en: 1'b0, used: 1'b1};
            res_in = '{status: bfpa_pkg::ST_OK, entry_index: FIB'(best_idx_ff),
                       entry_allocated: 1'b1, entry_owner: req_ff.process_id,
                       entry_size: FSB'(best_size_ff), entry_leftover: FSB'(best_left)};
            state_in = bfpa_pkg::S_RESP;
         end

         bfpa_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = bfpa_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = bfpa_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/best_fit_partition_allocator_top.sv @@
// Best-fit partition allocator, top level: CSR block, sequencer and partition store.
// A load writes the entry, a read fetches it through the registered read port, and an
// out-of-range load or read goes straight to the result state. An allocate steps the
// single comparator through the active entries of the store one entry per cycle, then a
// drain, a commit (skipped when nothing fits) and the result state.
// One request at a time; the sequencer is idle again once its result is offered.
// Synchronous reset clears the used flags and sets active_blocks to 16; sizes, owners and
// leftovers hold no value until loaded. Depends on bfpa_pkg, bfpa_engine, bfpa_store.
module best_fit_partition_allocator_top #(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_BITS  = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  bfpa_pkg::req_beat_type                req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output bfpa_pkg::rsp_beat_type                rsp_data,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [bfpa_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [bfpa_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [bfpa_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready
);

   localparam int IDX_BITS = $clog2(NUM_BLOCKS);

   logic [bfpa_pkg::ACTIVE_BITS-1:0] active_ff, active_in;
   logic                             csr_hit;

   bfpa_pkg::wr_ctl_type  wr_ctl;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [SIZE_BITS-1:0]  wr_size;
   logic [7:0]            wr_owner;
   logic [SIZE_BITS-1:0]  wr_leftover;
   logic                  rd_en;
   logic [IDX_BITS-1:0]   rd_addr;
   logic [SIZE_BITS-1:0]  rd_size;
   logic [7:0]            rd_owner;
   logic [SIZE_BITS-1:0]  rd_leftover;
   logic                  rd_used;

   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[2] == bfpa_pkg::CSR_IDX_ACTIVE;

   always_comb begin
      active_in = active_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         active_in = csr_pwdata[bfpa_pkg::ACTIVE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= bfpa_pkg::ACTIVE_RESET;
      end else begin
         active_ff <= active_in;
      end
   end

   assign csr_prdata = csr_hit ? bfpa_pkg::CSR_DATA_BITS'(active_ff) : '0;

   bfpa_engine #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS),
      .IDX_BITS   (IDX_BITS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .active_blocks (active_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .wr_ctl        (wr_ctl),
      .wr_addr       (wr_addr),
      .wr_size       (wr_size),
      .wr_owner      (wr_owner),
      .wr_leftover   (wr_leftover),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_size       (rd_size),
      .rd_owner      (rd_owner),
      .rd_leftover   (rd_leftover),
      .rd_used       (rd_used)
   );

   bfpa_store #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS),
      .IDX_BITS   (IDX_BITS)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .wr_ctl      (wr_ctl),
      .wr_addr     (wr_addr),
      .wr_size     (wr_size),
      .wr_owner    (wr_owner),
      .wr_leftover (wr_leftover),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_size     (rd_size),
      .rd_owner    (rd_owner),
      .rd_leftover (rd_leftover),
      .rd_used     (rd_used)
   );

endmodule
